// ===== hdl/animation_frame_time_lookup_macros.svh =====
// assertion helpers for the frame time lookup block
`ifndef ANIMATION_FRAME_TIME_LOOKUP_MACROS_SVH
`define ANIMATION_FRAME_TIME_LOOKUP_MACROS_SVH

// consequent checked in the same cycle
`define AFTL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the following cycle
`define AFTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/aftl_pkg.sv =====
package aftl_pkg;

    localparam int AFTL_MAX_FRAMES  = 256;
    localparam int AFTL_DELAY_BITS  = 16;

    localparam int TIME_W      = 24;
    localparam int QT_W        = 32;
    localparam int DELAY_W     = 16;
    localparam int FNUM_W      = 8;
    localparam int IDX_OUT_W   = 8;
    localparam int FRAC_W      = 17;
    localparam int STEP_W      = 6;
    localparam int OP_W        = 2;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (IDX_OUT_W + 1 + FRAC_W + 1);

    localparam int OUT_FOUND_BIT = IDX_OUT_W;
    localparam int OUT_FRAC_LSB  = IDX_OUT_W + 1;
    localparam int OUT_FULL_BIT  = IDX_OUT_W + 1 + FRAC_W;

    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND   = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
    localparam logic [OP_W-1:0] OP_PROGRESS = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [FRAC_W-1:0] FULL_FRAC = 17'h10000;

    localparam logic [STEP_W-1:0] MOD_STEPS  = 6'd32;
    localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd16;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_sts_t;

endpackage

// ===== hdl/aftl_serial_div.sv =====
module aftl_serial_div
    import aftl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctl_t          ctl,
    input  logic [TIME_W-1:0] rem_init,
    input  logic [QT_W-1:0]   dividend,
    input  logic [TIME_W-1:0] divisor,
    output div_sts_t          sts,
    output logic [TIME_W-1:0] remainder,
    output logic [QT_W-1:0]   quotient
);

    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [QT_W-1:0]   dvd_reg, dvd_next;
    logic [TIME_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [TIME_W:0]   trial;
    logic [TIME_W+1:0] diff;
    logic              ge;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, dvd_reg[QT_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign ge    = ~diff[TIME_W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = rem_init;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = ctl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            dvd_next = {dvd_reg[QT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == {{(STEP_W-1){1'b0}}, 1'b1})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign sts.done     = done_reg;
    assign sts.rem_zero = (rem_reg == '0);
    assign remainder    = rem_reg;
    assign quotient     = dvd_reg;

endmodule

// ===== hdl/aftl_table.sv =====
module aftl_table
    import aftl_pkg::*;
#(
    parameter int DEPTH = AFTL_MAX_FRAMES,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [TIME_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/animation_frame_time_lookup.sv =====
// Frame time lookup: keeps running end times of up to MAX_FRAMES frames and
// takes one transaction at a time. Clear and append go straight from
// acceptance to the output state. A search runs a binary search over the
// single read port of the end time memory (one read and one compare per
// step). A progress query reads the frame's end and start times and, when
// the time lies inside the frame, runs 16 steps of the shared bit-serial
// divider to form the Q1.16 fraction. With looping on and a nonzero total,
// the time first passes the 32 serial steps of the time modulo. The memory
// needs no clearing: only entries below the frame count are read.
module animation_frame_time_lookup
    import aftl_pkg::*;
#(
    parameter int MAX_FRAMES = AFTL_MAX_FRAMES,
    parameter int DELAY_BITS = AFTL_DELAY_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // frame_delay[15:0], query_time[47:16], loop_mode[48], frame_number[56:49]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // frame_index[7:0], frame_found[8], progress_fraction[25:9], table_full[26]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam logic [DELAY_W-1:0] DELAY_MASK = (DELAY_BITS >= DELAY_W) ?
        {DELAY_W{1'b1}} : DELAY_W'((64'd1 << DELAY_BITS) - 64'd1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MOD      = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_BS_ADDR  = 4'd3;
    localparam logic [3:0] S_BS_CMP   = 4'd4;
    localparam logic [3:0] S_PR_END   = 4'd5;
    localparam logic [3:0] S_PR_START = 4'd6;
    localparam logic [3:0] S_PR_CMP   = 4'd7;
    localparam logic [3:0] S_FRAC     = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [FNUM_W-1:0]      fnum_reg, fnum_next;
    logic [QT_W-1:0]        t_reg, t_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TIME_W-1:0]      total_reg, total_next;
    logic [IDX_W-1:0]       lo_reg, lo_next;
    logic [IDX_W-1:0]       hi_reg, hi_next;
    logic [TIME_W-1:0]      et_reg, et_next;
    logic [IDX_OUT_W-1:0]   res_idx_reg, res_idx_next;
    logic                   res_found_reg, res_found_next;
    logic [FRAC_W-1:0]      res_frac_reg, res_frac_next;
    logic                   res_full_reg, res_full_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                   s_accept;
    logic [OP_W-1:0]        in_op;
    logic [DELAY_W-1:0]     in_delay;
    logic [QT_W-1:0]        in_qtime;
    logic                   in_loop;
    logic [FNUM_W-1:0]      in_fnum;

    logic                   tbl_full;
    logic                   in_range;
    logic                   need_wrap;
    logic [TIME_W:0]        sum_raw;
    logic [TIME_W-1:0]      sum_sat;
    logic [CNT_W-1:0]       count_m1;
    logic [CNT_W+IDX_OUT_W-1:0]  cnt_ext;
    logic [CNT_W+IDX_OUT_W-1:0]  cm1_ext;
    logic [IDX_W+IDX_OUT_W-1:0]  lo_ext;
    logic [IDX_W+FNUM_W-1:0]     fnum_ext;
    logic [IDX_W-1:0]       fnum_idx;
    logic [IDX_W:0]         mid_sum;
    logic [IDX_W-1:0]       mid;

    logic                   wr_en;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [TIME_W-1:0]      rd_data;

    logic [TIME_W-1:0]      st;
    logic                   t_le_st;
    logic                   t_ge_et;
    logic [TIME_W-1:0]      wrapped;

    div_ctl_t               div_ctl;
    div_sts_t               div_sts;
    logic [TIME_W-1:0]      div_rem_init;
    logic [QT_W-1:0]        div_dividend;
    logic [TIME_W-1:0]      div_divisor;
    logic [TIME_W-1:0]      div_rem;
    logic [QT_W-1:0]        div_quo;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    assign in_op    = s_axis_tuser;
    assign in_delay = s_axis_tdata[15:0] & DELAY_MASK;
    assign in_qtime = s_axis_tdata[47:16];
    assign in_loop  = s_axis_tdata[48];
    assign in_fnum  = s_axis_tdata[56:49];

    assign tbl_full = (count_reg >= CNT_W'(MAX_FRAMES));
    assign in_range = ({{CNT_W{1'b0}}, in_fnum} < {{FNUM_W{1'b0}}, count_reg});
    assign need_wrap = in_loop && (total_reg != '0) &&
                       (((in_op == OP_SEARCH) && (count_reg != '0)) ||
                        ((in_op == OP_PROGRESS) && in_range));

    // saturating running total
    assign sum_raw = {1'b0, total_reg} + {{(TIME_W+1-DELAY_W){1'b0}}, in_delay};
    assign sum_sat = sum_raw[TIME_W] ? TIME_MAX : sum_raw[TIME_W-1:0];

    assign count_m1 = count_reg - 1'b1;
    assign cnt_ext  = {{IDX_OUT_W{1'b0}}, count_reg};
    assign cm1_ext  = {{IDX_OUT_W{1'b0}}, count_m1};
    assign lo_ext   = {{IDX_OUT_W{1'b0}}, lo_reg};
    assign fnum_ext = {{IDX_W{1'b0}}, fnum_reg};
    assign fnum_idx = fnum_ext[IDX_W-1:0];

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];

    assign wr_en = s_accept && (in_op == OP_APPEND) && !tbl_full;

    assign st      = (fnum_reg == '0) ? '0 : rd_data;
    assign t_le_st = (t_reg <= {{(QT_W-TIME_W){1'b0}}, st});
    assign t_ge_et = (t_reg >= {{(QT_W-TIME_W){1'b0}}, et_reg});

    // nonzero time with zero remainder maps to the total
    assign wrapped = ((t_reg != '0) && div_sts.rem_zero) ? total_reg : div_rem;

    always_comb
    begin
        if (state_reg == S_PR_CMP)
        begin
            div_ctl.start = !t_le_st && !t_ge_et;
            div_ctl.steps = FRAC_STEPS;
            div_rem_init  = t_reg[TIME_W-1:0] - st;
            div_dividend  = '0;
            div_divisor   = et_reg - st;
        end
        else
        begin
            div_ctl.start = s_accept && need_wrap;
            div_ctl.steps = MOD_STEPS;
            div_rem_init  = '0;
            div_dividend  = in_qtime;
            div_divisor   = total_reg;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_BS_ADDR:
            begin
                rd_en   = (lo_reg != hi_reg);
                rd_addr = mid;
            end
            S_PR_END:
            begin
                rd_en   = 1'b1;
                rd_addr = fnum_idx;
            end
            S_PR_START:
            begin
                rd_en   = 1'b1;
                rd_addr = fnum_idx - 1'b1;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = mid;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        fnum_next      = fnum_reg;
        t_next         = t_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        et_next        = et_reg;
        res_idx_next   = res_idx_reg;
        res_found_next = res_found_reg;
        res_frac_next  = res_frac_reg;
        res_full_next  = res_full_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next        = in_op;
                    fnum_next      = in_fnum;
                    t_next         = in_qtime;
                    res_idx_next   = '0;
                    res_found_next = 1'b0;
                    res_frac_next  = '0;
                    res_full_next  = 1'b0;
                    state_next     = S_OUT;
                    case (in_op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (tbl_full)
                            begin
                                res_full_next = 1'b1;
                                res_idx_next  = cm1_ext[IDX_OUT_W-1:0];
                            end
                            else
                            begin
                                count_next   = count_reg + 1'b1;
                                total_next   = sum_sat;
                                res_idx_next = cnt_ext[IDX_OUT_W-1:0];
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                res_found_next = 1'b1;
                                if (total_reg != '0)
                                begin
                                    state_next = need_wrap ? S_MOD : S_DISPATCH;
                                end
                            end
                        end
                        OP_PROGRESS:
                        begin
                            if (in_range)
                            begin
                                res_found_next = 1'b1;
                                state_next     = need_wrap ? S_MOD : S_DISPATCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (div_sts.done)
                begin
                    t_next     = {{(QT_W-TIME_W){1'b0}}, wrapped};
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (op_reg == OP_SEARCH)
                begin
                    if (t_reg == '0)
                    begin
                        res_idx_next = '0;
                        state_next   = S_OUT;
                    end
                    else if (t_reg >= {{(QT_W-TIME_W){1'b0}}, total_reg})
                    begin
                        res_idx_next = cm1_ext[IDX_OUT_W-1:0];
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = count_m1[IDX_W-1:0];
                        state_next = S_BS_ADDR;
                    end
                end
                else
                begin
                    state_next = S_PR_END;
                end
            end
            S_BS_ADDR:
            begin
                if (lo_reg == hi_reg)
                begin
                    res_idx_next = lo_ext[IDX_OUT_W-1:0];
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_BS_CMP;
                end
            end
            S_BS_CMP:
            begin
                if (t_reg <= {{(QT_W-TIME_W){1'b0}}, rd_data})
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + 1'b1;
                end
                state_next = S_BS_ADDR;
            end
            S_PR_END:
            begin
                state_next = S_PR_START;
            end
            S_PR_START:
            begin
                et_next    = rd_data;
                state_next = S_PR_CMP;
            end
            S_PR_CMP:
            begin
                if (t_le_st)
                begin
                    res_frac_next = '0;
                    state_next    = S_OUT;
                end
                else if (t_ge_et)
                begin
                    res_frac_next = FULL_FRAC;
                    state_next    = S_OUT;
                end
                else
                begin
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (div_sts.done)
                begin
                    res_frac_next = {1'b0, div_quo[FRAC_W-2:0]};
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = {{OUT_PAD_W{1'b0}}, res_full_reg, res_frac_reg,
                                    res_found_reg, res_idx_reg};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        fnum_reg      <= fnum_next;
        t_reg         <= t_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        et_reg        <= et_next;
        res_idx_reg   <= res_idx_next;
        res_found_reg <= res_found_next;
        res_frac_reg  <= res_frac_next;
        res_full_reg  <= res_full_next;
        m_data_reg    <= m_data_next;
    end

    aftl_table #(
        .DEPTH (MAX_FRAMES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (sum_sat),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    aftl_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .sts       (div_sts),
        .remainder (div_rem),
        .quotient  (div_quo)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== hdl/aftl_checker.sv =====
`include "animation_frame_time_lookup_macros.svh"

module aftl_checker
    import aftl_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
)
;

    logic s_accept;
    logic m_stall;
    logic frac_full;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign m_stall   = m_axis_tvalid && !m_axis_tready;
    assign frac_full = m_axis_tdata[OUT_FRAC_LSB+FRAC_W-1];

    // stalled result holds
    `AFTL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // one transaction in work at a time
    `AFTL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_accept, !s_axis_tready, "ready stayed high after accept")

    // refused append never reports a found frame
    `AFTL_ASSERT_SAME(a_full_not_found, clk, rst_n, m_axis_tvalid, !(m_axis_tdata[OUT_FULL_BIT] && m_axis_tdata[OUT_FOUND_BIT]), "table_full with frame_found")

    // fraction never exceeds one
    `AFTL_ASSERT_SAME(a_frac_range, clk, rst_n, m_axis_tvalid && frac_full, m_axis_tdata[OUT_FRAC_LSB+FRAC_W-2:OUT_FRAC_LSB] == '0, "progress above one")

endmodule

bind animation_frame_time_lookup aftl_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
